// ===== rtl/b2b_pkg.sv =====
package b2b_pkg;

    localparam logic [63:0] IV_TAB [8] = '{
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
        64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
        64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0040;
    localparam int NUM_ROUNDS = 12;

    typedef logic [63:0] word_t;

    function automatic logic [3:0] sigma(input logic [3:0] round, input logic [3:0] idx);
        logic [63:0] row;
        begin
            unique case (round)
                4'd0, 4'd10: row = 64'hFEDCBA9876543210;
                4'd1, 4'd11: row = 64'h357B20C16DF984AE;
                4'd2: row = 64'h491763EADF250C8B;
                4'd3: row = 64'h8F04A562EBCD1397;
                4'd4: row = 64'hD386CB1EFA427509;
                4'd5: row = 64'h91EF57D438B0A6C2;
                4'd6: row = 64'hB8293670A4DEF15C;
                4'd7: row = 64'hA2684F05931CE7BD;
                4'd8: row = 64'h5A417D2C803B9EF6;
                4'd9: row = 64'h0DC3E9BF5167482A;
                default: row = 64'hFEDCBA9876543210;
            endcase
            sigma = row[idx*4 +: 4];
        end
    endfunction

endpackage

// ===== rtl/blake2b_hash_engine_core.sv =====
// BLAKE2b-512 engine. Send message words on s_axis (tdata: data_word[63:0],
// byte_count[67:64]; tlast: last_word). A word is first accepted into a
// pending register and then stored, so no new word is taken until the last
// one is stored; the word that follows a full 16-word buffer first waits for a
// compression, which runs 12 rounds of 8 G steps through one shared G unit
// (one 64-bit add-xor-rotate quarter of G per cycle while cfg_we is low),
// between a setup state and a finish state. The last word pads, runs the final
// compression and then returns 8 digest words on m_axis, word 0 first, tlast on
// word 7. Writing key_len (0..64, higher taken as 64) restarts the message.
module blake2b_hash_engine_core
    import b2b_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_word[63:0], byte_count[67:64]
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // digest_word[63:0]
    output logic        m_axis_tlast    // digest_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_G    = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg;
    logic [6:0]  key_len_reg;
    word_t       h_reg [8];
    word_t       v_reg [16];
    word_t       m_reg [16];
    logic [4:0]  fill_reg;
    logic [63:0] tlo_reg;
    logic [63:0] thi_reg;
    logic [3:0]  round_reg;
    logic [2:0]  gidx_reg;
    logic [1:0]  step_reg;
    logic        final_reg;
    logic        pend_reg;      // accepted word waiting to enter buffer (also across a compression)
    word_t       pend_word_reg;
    logic        pend_last_reg;
    logic [3:0]  pend_bc_reg;
    logic [2:0]  out_idx_reg;

    logic [3:0] ia, ib, ic, id;
    word_t      va, vb, vc, vd, mx, sum, xr, rot;
    logic [3:0] bc_sat;
    word_t      masked;
    logic [6:0] key_sat;

    always_comb
    begin
        unique case (gidx_reg)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        va = v_reg[ia];
        vb = v_reg[ib];
        vc = v_reg[ic];
        vd = v_reg[id];
        mx = m_reg[sigma(round_reg, {gidx_reg, step_reg[1]})];
        sum = '0;
        xr  = '0;
        rot = '0;
        unique case (step_reg)
            2'd0, 2'd2:
            begin
                sum = va + vb + mx;
                xr  = vd ^ sum;
                rot = (step_reg == 2'd0) ? {xr[31:0], xr[63:32]} : {xr[15:0], xr[63:16]};
            end
            default:
            begin
                sum = vc + vd;
                xr  = vb ^ sum;
                rot = (step_reg == 2'd1) ? {xr[23:0], xr[63:24]} : {xr[62:0], xr[63]};
            end
        endcase
    end

    always_comb
    begin
        bc_sat = (pend_bc_reg > 4'd8) ? 4'd8 : pend_bc_reg;
        masked = pend_word_reg;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) >= bc_sat)
            begin
                masked[i*8 +: 8] = 8'h00;
            end
        end
        key_sat = (cfg_wdata > 7'd64) ? 7'd64 : cfg_wdata;
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !pend_reg;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = h_reg[out_idx_reg];
    assign m_axis_tlast  = (out_idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            key_len_reg <= '0;
            fill_reg    <= '0;
            tlo_reg     <= '0;
            thi_reg     <= '0;
            pend_reg    <= 1'b0;
            final_reg   <= 1'b0;
            round_reg   <= '0;
            gidx_reg    <= '0;
            step_reg    <= '0;
            out_idx_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= (i == 0) ? (IV_TAB[0] ^ PARAM_BASE) : IV_TAB[i];
            end
        end
        else if (cfg_we)
        begin
            key_len_reg <= key_sat;
            fill_reg    <= '0;
            tlo_reg     <= '0;
            thi_reg     <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= (i == 0) ? (IV_TAB[0] ^ PARAM_BASE ^ {49'd0, key_sat, 8'd0})
                                     : IV_TAB[i];
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        pend_reg      <= 1'b1;
                        pend_word_reg <= s_axis_tdata[63:0];
                        pend_bc_reg   <= s_axis_tdata[67:64];
                        pend_last_reg <= s_axis_tlast;
                    end
                    else if (pend_reg)
                    begin
                        if (!pend_last_reg)
                        begin
                            if (fill_reg[4])
                            begin
                                {thi_reg, tlo_reg} <= {thi_reg, tlo_reg} + 128'd128;
                                final_reg <= 1'b0;
                                fill_reg  <= '0;
                                state_reg <= ST_INIT;
                            end
                            else
                            begin
                                m_reg[fill_reg[3:0]] <= pend_word_reg;
                                fill_reg <= fill_reg + 5'd1;
                                pend_reg <= 1'b0;
                            end
                        end
                        else if (fill_reg[4] && bc_sat != 4'd0)
                        begin
                            {thi_reg, tlo_reg} <= {thi_reg, tlo_reg} + 128'd128;
                            final_reg <= 1'b0;
                            fill_reg  <= '0;
                            state_reg <= ST_INIT;
                        end
                        else
                        begin
                            if (!fill_reg[4])
                            begin
                                for (int i = 0; i < 16; i++)
                                begin
                                    if (5'(i) == fill_reg)
                                    begin
                                        m_reg[i] <= masked;
                                    end
                                    else if (5'(i) > fill_reg)
                                    begin
                                        m_reg[i] <= '0;
                                    end
                                end
                                {thi_reg, tlo_reg} <= {thi_reg, tlo_reg}
                                    + {121'd0, fill_reg[3:0], 3'd0} + {124'd0, bc_sat};
                            end
                            else
                            begin
                                {thi_reg, tlo_reg} <= {thi_reg, tlo_reg} + 128'd128;
                            end
                            pend_reg  <= 1'b0;
                            final_reg <= 1'b1;
                            state_reg <= ST_INIT;
                        end
                    end
                end
                ST_INIT:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        v_reg[i] <= h_reg[i];
                    end
                    for (int i = 0; i < 4; i++)
                    begin
                        v_reg[i + 8] <= IV_TAB[i];
                    end
                    v_reg[12] <= IV_TAB[4] ^ tlo_reg;
                    v_reg[13] <= IV_TAB[5] ^ thi_reg;
                    v_reg[14] <= final_reg ? ~IV_TAB[6] : IV_TAB[6];
                    v_reg[15] <= IV_TAB[7];
                    round_reg <= '0;
                    gidx_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_G;
                end
                ST_G:
                begin
                    if (step_reg == 2'd0 || step_reg == 2'd2)
                    begin
                        v_reg[ia] <= sum;
                        v_reg[id] <= rot;
                    end
                    else
                    begin
                        v_reg[ic] <= sum;
                        v_reg[ib] <= rot;
                    end
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        gidx_reg <= gidx_reg + 3'd1;
                        if (gidx_reg == 3'd7)
                        begin
                            round_reg <= round_reg + 4'd1;
                            if (round_reg == 4'(NUM_ROUNDS - 1))
                            begin
                                state_reg <= ST_FIN;
                            end
                        end
                    end
                end
                ST_FIN:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i + 8];
                    end
                    out_idx_reg <= '0;
                    state_reg   <= final_reg ? ST_OUT : ST_IDLE;
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_idx_reg <= out_idx_reg + 3'd1;
                        if (out_idx_reg == 3'd7)
                        begin
                            fill_reg  <= '0;
                            tlo_reg   <= '0;
                            thi_reg   <= '0;
                            final_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= (i == 0)
                                    ? (IV_TAB[0] ^ PARAM_BASE ^ {49'd0, key_len_reg, 8'd0})
                                    : IV_TAB[i];
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while digest pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast && !cfg_we) |=> s_axis_tready == !pend_reg)
        else $error("engine not idle after digest");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_G) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("handshake open during compression");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 5'd16)
        else $error("buffer fill out of range");

endmodule
